### src/reserved_region_table_core_defines.svh
// Assertion helpers used by the RTL.
`ifndef RESERVED_REGION_TABLE_CORE_DEFINES_SVH
`define RESERVED_REGION_TABLE_CORE_DEFINES_SVH

// Same-cycle implication.
`define RRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/rrt_pkg.sv
package rrt_pkg;

   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int CSR_W    = 5;
   localparam int PORT_W   = 32;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ALIGN   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd3;

   localparam logic [CSR_W-1:0] MAX_REGIONS_RST = 5'd16;

   typedef struct packed {
      logic capture;
      logic insert;
   } rrt_ctrl_type;

endpackage

### src/rrt_cell.sv
module rrt_cell #(
   parameter int DATA_W = 32,
   parameter int CNT_W  = 5,
   parameter int INDEX  = 0
) (
   input  logic                  clock,
   input  rrt_pkg::rrt_ctrl_type ctrl,
   input  logic [CNT_W-1:0]      count,
   input  logic [DATA_W-1:0]     cmp_start,
   input  logic [DATA_W-1:0]     cmp_size,
   input  logic [DATA_W-1:0]     ins_start,
   input  logic [DATA_W-1:0]     ins_size,
   input  logic [DATA_W-1:0]     prev_start,
   input  logic [DATA_W-1:0]     prev_size,
   input  logic                  prev_ge,
   output logic [DATA_W-1:0]     start_o,
   output logic [DATA_W-1:0]     size_o,
   output logic                  ge_o,
   output logic                  clash_o
);

   logic [DATA_W-1:0] start_ff, start_in;
   logic [DATA_W-1:0] size_ff, size_in;
   logic              ge_ff, ge_in;
   logic              clash_ff, clash_in;
   logic              valid;
   logic              new_lower;
   logic [DATA_W-1:0] lo_start, lo_size, hi_start;
   logic [DATA_W:0]   lo_end;

   assign valid     = count > CNT_W'(INDEX);
   assign new_lower = cmp_start < start_ff;

   always_comb begin
      if (new_lower) begin
         lo_start = cmp_start;
         lo_size  = cmp_size;
         hi_start = start_ff;
      end else begin
         lo_start = start_ff;
         lo_size  = size_ff;
         hi_start = cmp_start;
      end
      lo_end   = {1'b0, lo_start} + {1'b0, lo_size};
      clash_in = valid && (lo_end > {1'b0, hi_start});
      ge_in    = valid && (start_ff >= cmp_start);
   end

   // sorted insert: keep, take the new region, or take the neighbour's
   always_comb begin
      start_in = start_ff;
      size_in  = size_ff;
      if (ctrl.insert && !ge_ff) begin
         if (prev_ge) begin
            start_in = ins_start;
            size_in  = ins_size;
         end else begin
            start_in = prev_start;
            size_in  = prev_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      size_ff  <= size_in;
      if (ctrl.capture) begin
         ge_ff    <= ge_in;
         clash_ff <= clash_in;
      end
   end

   assign start_o = start_ff;
   assign size_o  = size_ff;
   assign ge_o    = ge_ff;
   assign clash_o = clash_ff;

endmodule

### src/reserved_region_table_core.sv
// Reserved region table: holds up to TABLE_DEPTH regions sorted by start
// address, highest first, one region per cell of a shifting chain. A request
// is taken when start is high and busy is low; every cell compares it against
// its own region in that cycle, and in the next cycle the status is decided
// and the region, if accepted, is shifted into place. An item therefore goes
// through the compare stage in the cells and then the insert shift, and busy
// holds off new requests until then. Exactly one result follows each request,
// shown for one cycle with rsp_valid high, and the receiver cannot stall it.
// Status: 0 reserved, 1 not frame aligned, 2 table full, 3 overlaps a stored region.
`include "reserved_region_table_core_defines.svh"

module reserved_region_table_core #(
   parameter int TABLE_DEPTH = 16,
   parameter int FRAME_BITS  = 12,
   parameter int ADDR_BITS   = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [rrt_pkg::PORT_W-1:0]     req_region_start,
   input  logic [rrt_pkg::PORT_W-1:0]     req_region_size,
   output logic                           rsp_valid,
   output logic [rrt_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rrt_pkg::COUNT_W-1:0]    rsp_region_count,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rrt_pkg::CSR_W-1:0]      csr_data
);

   localparam int DW = (ADDR_BITS < rrt_pkg::PORT_W) ? ADDR_BITS : rrt_pkg::PORT_W;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int LW = (CW > rrt_pkg::CSR_W) ? CW : rrt_pkg::CSR_W;
   localparam logic [DW-1:0] ALIGN_MASK = DW'((64'd1 << FRAME_BITS) - 64'd1);

   logic                          busy_ff, busy_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [rrt_pkg::CSR_W-1:0]     limit_ff, limit_in;
   logic [DW-1:0]                 req_start_ff, req_start_in;
   logic [DW-1:0]                 req_size_ff, req_size_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rrt_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [rrt_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                          accept;
   logic [DW-1:0]                 cmp_start, cmp_size;
   logic [LW-1:0]                 limit_eff;
   logic                          misaligned, full, overlap;
   logic [rrt_pkg::STATUS_W-1:0]  status;
   rrt_pkg::rrt_ctrl_type         ctrl;

   logic [DW-1:0]                 cell_start [TABLE_DEPTH];
   logic [DW-1:0]                 cell_size  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]        cell_ge;
   logic [TABLE_DEPTH-1:0]        cell_clash;

   assign accept    = start && !busy_ff;
   assign cmp_start = req_region_start[DW-1:0];
   assign cmp_size  = req_region_size[DW-1:0];

   assign limit_eff  = (LW'(limit_ff) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(limit_ff);
   assign misaligned = |((req_start_ff | req_size_ff) & ALIGN_MASK);
   assign full       = LW'(count_ff) >= limit_eff;
   assign overlap    = |cell_clash;

   always_comb begin
      priority if (misaligned) begin
         status = rrt_pkg::ST_ALIGN;
      end else if (full) begin
         status = rrt_pkg::ST_FULL;
      end else if (overlap) begin
         status = rrt_pkg::ST_OVERLAP;
      end else begin
         status = rrt_pkg::ST_OK;
      end
   end

   assign ctrl.capture = accept;
   assign ctrl.insert  = busy_ff && (status == rrt_pkg::ST_OK);

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         logic [DW-1:0] prev_start, prev_size;
         logic          prev_ge;
         if (g == 0) begin : g_head
            assign prev_start = req_start_ff;
            assign prev_size  = req_size_ff;
            assign prev_ge    = 1'b1;
         end else begin : g_link
            assign prev_start = cell_start[g-1];
            assign prev_size  = cell_size[g-1];
            assign prev_ge    = cell_ge[g-1];
         end
         rrt_cell #(
            .DATA_W (DW),
            .CNT_W  (CW),
            .INDEX  (g)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .count      (count_ff),
            .cmp_start  (cmp_start),
            .cmp_size   (cmp_size),
            .ins_start  (req_start_ff),
            .ins_size   (req_size_ff),
            .prev_start (prev_start),
            .prev_size  (prev_size),
            .prev_ge    (prev_ge),
            .start_o    (cell_start[g]),
            .size_o     (cell_size[g]),
            .ge_o       (cell_ge[g]),
            .clash_o    (cell_clash[g])
         );
      end
   endgenerate

   always_comb begin
      busy_in       = busy_ff;
      count_in      = count_ff;
      limit_in      = limit_ff;
      req_start_in  = req_start_ff;
      req_size_in   = req_size_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (csr_valid && csr_ready) begin
         limit_in = csr_data;
      end
      if (accept) begin
         busy_in      = 1'b1;
         req_start_in = cmp_start;
         req_size_in  = cmp_size;
      end else if (busy_ff) begin
         busy_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         if (ctrl.insert) begin
            count_in = count_ff + 1'b1;
         end
         rsp_count_in = rrt_pkg::COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         limit_ff     <= rrt_pkg::MAX_REGIONS_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_start_ff  <= req_start_in;
      req_size_ff   <= req_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy             = busy_ff;
   assign csr_ready        = !busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_region_count = rsp_count_ff;

   `RRT_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy_ff && !rsp_valid_ff, "transaction not held busy")
   `RRT_ASSERT_NEXT(a_one_result, clock, reset, busy_ff, !busy_ff && rsp_valid_ff, "busy transaction gave no result")
   `RRT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(TABLE_DEPTH), "count beyond table depth")
   `RRT_ASSERT_NOW(a_ok_grows, clock, reset, rsp_valid_ff && (rsp_status_ff == rrt_pkg::ST_OK), count_ff == $past(count_ff) + 1'b1, "reserved without count step")
   `RRT_ASSERT_NOW(a_reject_keeps, clock, reset, rsp_valid_ff && (rsp_status_ff != rrt_pkg::ST_OK), $stable(count_ff), "rejected transaction changed count")

endmodule
